// File: src/clne_pkg.sv
// Shared types, constants and slot arithmetic for the circular neighbor engine.
`timescale 1ns / 1ps

package clne_pkg;

   // Link table depth; station ids are reduced modulo this count.
   localparam int NUM_STATIONS = 65536;

   localparam int ID_W   = 16;
   localparam int OP_W   = 3;
   localparam int ADDR_W = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;

   // Operation codes carried on the request channel
   localparam logic [OP_W-1:0] OP_LOAD       = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_AFTER  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd2;
   localparam logic [OP_W-1:0] OP_CLOSE_NEXT = 3'd3;
   localparam logic [OP_W-1:0] OP_CLOSE_PREV = 3'd4;

   // Reciprocal for id / NUM_STATIONS; the estimate is low by at most one.
   localparam int              SHIFT   = ID_W + ADDR_W;
   localparam longint unsigned RECIP   = (64'd1 << SHIFT) / NUM_STATIONS;
   localparam int              RECIP_W = SHIFT - ADDR_W + 2;
   localparam int              PROD_W  = RECIP_W + ID_W;
   localparam int              Q_W     = ID_W;
   localparam int              CALC_W  = ((ADDR_W > ID_W) ? ADDR_W : ID_W) + 1;

   // One link entry: the station id plus its precomputed table slot.
   typedef struct packed {
      logic [ADDR_W-1:0] slot;
      logic [ID_W-1:0]   id;
   } link_type;

   localparam int LINK_W = $bits(link_type);

   // First step of the slot reduction: quotient estimate.
   function automatic logic [Q_W-1:0] slot_quot(input logic [ID_W-1:0] id);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(id) * PROD_W'(RECIP);
      return Q_W'(prod >> SHIFT);
   endfunction

   // Second step: remainder with a single correction.
   function automatic logic [ADDR_W-1:0] slot_fix(input logic [ID_W-1:0] id,
                                                  input logic [Q_W-1:0]  q);
      logic [CALC_W-1:0] rem;
      rem = CALC_W'(id) - CALC_W'(q * NUM_STATIONS);
      if (rem >= CALC_W'(NUM_STATIONS)) begin
         rem = rem - CALC_W'(NUM_STATIONS);
      end
      return rem[ADDR_W-1:0];
   endfunction

endpackage

// File: src/circular_list_neighbor_engine_unit.sv
// Top level of the circular neighbor engine: ring of station ids in two link tables.
`timescale 1ns / 1ps

// Keeps a circular doubly linked ring of station ids in two single-port link
// tables (next and prev), each NUM_STATIONS deep, indexed by id modulo
// NUM_STATIONS. Every entry stores the linked id together with its table slot.
// One request transaction is handled at a time. Insert requests, closes that
// leave stations in the ring and loads into a non-empty ring pass, from
// acceptance to the next acceptance, through the accept state (slot quotient),
// an issue state (slot remainder, first read), a data state (first link writes
// or the far-side read) and a last link-write state, as each table has a single
// port. Closing the only station ends in the data state; loading into an empty
// ring and requests that give no response end in the issue state. A finished
// response sits in an output register, so a new request is taken while the
// previous response is still waiting; only if a second response is ready before
// the first is taken does the engine hold.
// The tables are not cleared: reading a link of a station never placed in
// the ring returns undefined data. Ids are not checked.

module circular_list_neighbor_engine_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [15:0] anchor_station, [31:16] new_station
   input  logic [2:0]  req_tuser,    // [2:0] opcode

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata     // [15:0] neighbor_station
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ISSUE,
      S_DATA,
      S_LINK,
      S_FAR,
      S_PEND
   } state_type;

   state_type                       state_ff, state_in;
   logic [clne_pkg::OP_W-1:0]       op_ff, op_in;
   logic [clne_pkg::ID_W-1:0]       a_id_ff, a_id_in;
   logic [clne_pkg::ID_W-1:0]       n_id_ff, n_id_in;
   logic [clne_pkg::Q_W-1:0]        a_q_ff, a_q_in;
   logic [clne_pkg::Q_W-1:0]        n_q_ff, n_q_in;
   logic [clne_pkg::ADDR_W-1:0]     a_slot_ff, a_slot_in;
   logic [clne_pkg::ADDR_W-1:0]     n_slot_ff, n_slot_in;
   clne_pkg::link_type              r_ff, r_in;
   clne_pkg::link_type              first_ff, first_in;
   logic [clne_pkg::ID_W-1:0]       last_id_ff, last_id_in;
   logic                            empty_ff, empty_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [clne_pkg::ID_W-1:0]       rsp_data_ff, rsp_data_in;

   // Link table ports
   logic                            nx_we, pv_we;
   logic [clne_pkg::ADDR_W-1:0]     nx_addr, pv_addr;
   clne_pkg::link_type              nx_wdata, pv_wdata;
   clne_pkg::link_type              nx_rdata, pv_rdata;

   logic [clne_pkg::ADDR_W-1:0]     a_slot_now, n_slot_now;
   clne_pkg::link_type              a_ent, n_ent, rd_ent;
   logic                            sel_next, out_free, done;
   logic [clne_pkg::ID_W-1:0]       done_val;

   clne_ram #(
      .WIDTH (clne_pkg::LINK_W),
      .DEPTH (clne_pkg::NUM_STATIONS)
   ) u_next_ram (
      .clock (clock),
      .we    (nx_we),
      .addr  (nx_addr),
      .wdata (nx_wdata),
      .rdata (nx_rdata)
   );

   clne_ram #(
      .WIDTH (clne_pkg::LINK_W),
      .DEPTH (clne_pkg::NUM_STATIONS)
   ) u_prev_ram (
      .clock (clock),
      .we    (pv_we),
      .addr  (pv_addr),
      .wdata (pv_wdata),
      .rdata (pv_rdata)
   );

   // Slot remainders, finished in the issue cycle from the registered quotients
   assign a_slot_now = clne_pkg::slot_fix(a_id_ff, a_q_ff);
   assign n_slot_now = clne_pkg::slot_fix(n_id_ff, n_q_ff);

   assign a_ent = '{slot: a_slot_ff, id: a_id_ff};
   assign n_ent = '{slot: n_slot_ff, id: n_id_ff};

   // Insert-after and close-next walk the next table; everything else prev.
   assign sel_next = (op_ff == clne_pkg::OP_INS_AFTER) || (op_ff == clne_pkg::OP_CLOSE_NEXT);
   assign rd_ent   = sel_next ? nx_rdata : pv_rdata;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      a_id_in      = a_id_ff;
      n_id_in      = n_id_ff;
      a_q_in       = a_q_ff;
      n_q_in       = n_q_ff;
      a_slot_in    = a_slot_ff;
      n_slot_in    = n_slot_ff;
      r_in         = r_ff;
      first_in     = first_ff;
      last_id_in   = last_id_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      nx_we    = 1'b0;
      pv_we    = 1'b0;
      nx_addr  = a_slot_ff;
      pv_addr  = a_slot_ff;
      nx_wdata = n_ent;
      pv_wdata = n_ent;

      done     = 1'b0;
      done_val = r_ff.id;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               a_id_in  = req_tdata[15:0];
               n_id_in  = req_tdata[31:16];
               a_q_in   = clne_pkg::slot_quot(req_tdata[15:0]);
               n_q_in   = clne_pkg::slot_quot(req_tdata[31:16]);
               state_in = S_ISSUE;
            end
         end

         S_ISSUE: begin
            a_slot_in = a_slot_now;
            n_slot_in = n_slot_now;
            if (op_ff == clne_pkg::OP_LOAD) begin
               if (empty_ff) begin
                  // first station links to itself on both sides
                  nx_we      = 1'b1;
                  pv_we      = 1'b1;
                  nx_addr    = n_slot_now;
                  pv_addr    = n_slot_now;
                  nx_wdata   = '{slot: n_slot_now, id: n_id_ff};
                  pv_wdata   = '{slot: n_slot_now, id: n_id_ff};
                  first_in   = '{slot: n_slot_now, id: n_id_ff};
                  last_id_in = n_id_ff;
                  empty_in   = 1'b0;
                  state_in   = S_IDLE;
               end else begin
                  // fetch the tail: prev of the first station
                  pv_addr  = first_ff.slot;
                  state_in = S_DATA;
               end
            end else if (op_ff > clne_pkg::OP_CLOSE_PREV || empty_ff) begin
               state_in = S_IDLE;
            end else begin
               nx_addr  = a_slot_now;
               pv_addr  = a_slot_now;
               state_in = S_DATA;
            end
         end

         S_DATA: begin
            r_in = rd_ent;
            if (op_ff == clne_pkg::OP_LOAD) begin
               pv_we    = 1'b1;
               pv_addr  = n_slot_ff;
               pv_wdata = rd_ent;
               nx_we    = 1'b1;
               nx_addr  = n_slot_ff;
               nx_wdata = first_ff;
               state_in = S_LINK;
            end else if (op_ff == clne_pkg::OP_INS_AFTER) begin
               pv_we    = 1'b1;
               pv_addr  = n_slot_ff;
               pv_wdata = a_ent;
               nx_we    = 1'b1;
               nx_addr  = n_slot_ff;
               nx_wdata = rd_ent;
               state_in = S_LINK;
            end else if (op_ff == clne_pkg::OP_INS_BEFORE) begin
               nx_we    = 1'b1;
               nx_addr  = n_slot_ff;
               nx_wdata = a_ent;
               pv_we    = 1'b1;
               pv_addr  = n_slot_ff;
               pv_wdata = rd_ent;
               state_in = S_LINK;
            end else if (rd_ent.id == a_id_ff) begin
               // closing the only station empties the ring
               empty_in = 1'b1;
               done     = 1'b1;
               done_val = rd_ent.id;
            end else begin
               // fetch the far side of the station being closed
               nx_addr  = rd_ent.slot;
               pv_addr  = rd_ent.slot;
               state_in = S_FAR;
            end
         end

         S_LINK: begin
            if (op_ff == clne_pkg::OP_LOAD) begin
               nx_we      = 1'b1;
               nx_addr    = r_ff.slot;
               pv_we      = 1'b1;
               pv_addr    = first_ff.slot;
               last_id_in = n_id_ff;
               state_in   = S_IDLE;
            end else if (op_ff == clne_pkg::OP_INS_AFTER) begin
               pv_we   = 1'b1;
               pv_addr = r_ff.slot;
               nx_we   = 1'b1;
               nx_addr = a_slot_ff;
               if (a_id_ff == last_id_ff) begin
                  last_id_in = n_id_ff;
               end
               done = 1'b1;
            end else begin
               nx_we   = 1'b1;
               nx_addr = r_ff.slot;
               pv_we   = 1'b1;
               pv_addr = a_slot_ff;
               if (a_id_ff == first_ff.id) begin
                  first_in = n_ent;
               end
               done = 1'b1;
            end
         end

         S_FAR: begin
            if (op_ff == clne_pkg::OP_CLOSE_NEXT) begin
               pv_we    = 1'b1;
               pv_addr  = rd_ent.slot;
               pv_wdata = a_ent;
               nx_we    = 1'b1;
               nx_addr  = a_slot_ff;
               nx_wdata = rd_ent;
               if (r_ff.id == first_ff.id) begin
                  first_in = rd_ent;
               end
               if (r_ff.id == last_id_ff) begin
                  last_id_in = a_id_ff;
               end
            end else begin
               nx_we    = 1'b1;
               nx_addr  = rd_ent.slot;
               nx_wdata = a_ent;
               pv_we    = 1'b1;
               pv_addr  = a_slot_ff;
               pv_wdata = rd_ent;
               if (r_ff.id == first_ff.id) begin
                  first_in = a_ent;
               end
               if (r_ff.id == last_id_ff) begin
                  last_id_in = rd_ent.id;
               end
            end
            done = 1'b1;
         end

         S_PEND: begin
            // response held until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = r_ff.id;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (done) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = done_val;
            state_in     = S_IDLE;
         end else begin
            state_in = S_PEND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= '0;
         last_id_ff   <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         last_id_ff   <= last_id_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      a_id_ff     <= a_id_in;
      n_id_ff     <= n_id_in;
      a_q_ff      <= a_q_in;
      n_q_ff      <= n_q_in;
      a_slot_ff   <= a_slot_in;
      n_slot_ff   <= n_slot_in;
      r_ff        <= r_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: src/clne_ram.sv
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps

module clne_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [$clog2(DEPTH)-1:0]   addr,
   input  logic [WIDTH-1:0]           wdata,
   output logic [WIDTH-1:0]           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sim/circular_list_neighbor_engine_unit_tb.sv
// Self-checking testbench for the circular neighbor engine: ring model, random streams.
`timescale 1ns / 1ps

module circular_list_neighbor_engine_unit_tb;

   typedef logic [clne_pkg::ID_W-1:0] id_type;
   typedef logic [clne_pkg::OP_W-1:0] op_type;

   // Opcodes past close-prev; the engine drops them without a response
   localparam op_type OP_SPARE_LO  = 3'd5;
   localparam op_type OP_SPARE_MID = 3'd6;
   localparam op_type OP_SPARE_HI  = 3'd7;

   localparam int RANDOM_CMDS    = 950;
   localparam int WATCHDOG_LIMIT = 2000;   // idle cycles; exceeds the long hold-off
   localparam int HOLD_CYCLES    = 200;
   localparam int DRAIN_CYCLES   = 16;

   // One request transaction plus the neighbor it must produce
   typedef struct {
      op_type op;
      id_type anchor;
      id_type station;
      bit     gives_nb;
      id_type nb;
   } ring_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [15:0] anchor_station, [31:16] new_station
   logic [2:0]  req_tuser = '0;    // [2:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [15:0] neighbor_station

   circular_list_neighbor_engine_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Ring model: link tables, start of ring, last appended, empty flag
   // ---------------------------------------------------------------------
   bit [clne_pkg::ID_W-1:0] next_tbl [clne_pkg::NUM_STATIONS];
   bit [clne_pkg::ID_W-1:0] prev_tbl [clne_pkg::NUM_STATIONS];
   bit [clne_pkg::ID_W-1:0] ring_head   = '0;
   bit [clne_pkg::ID_W-1:0] tail_loaded = '0;
   bit                      ring_vacant = 1'b1;

   // Stimulus bookkeeping: slots whose links hold data, and a rough ring size
   bit            id_seen [clne_pkg::NUM_STATIONS];
   id_type        known_ids [$];
   int            ring_len = 0;

   ring_cmd_type  pending_q  [$];   // built before reset, drained by the driver
   id_type        neighbor_q [$];   // neighbors owed by the engine, oldest first

   int fail_count = 0;
   int total_cmds = 0;              // requests built for the run
   int sent_count = 0;              // requests accepted by the engine

   function automatic int unsigned tbl_idx(input id_type id);
      return int'(id) % clne_pkg::NUM_STATIONS;
   endfunction

   // Applies one request to the ring model; returns the neighbor if one is due.
   function automatic void step_ring(input op_type  op,
                                     input id_type  a,
                                     input id_type  n,
                                     output bit     gives,
                                     output id_type nb);
      bit [clne_pkg::ID_W-1:0] r, far, tail;
      gives = 1'b0;
      nb    = '0;
      if (op == clne_pkg::OP_LOAD) begin
         if (ring_vacant) begin
            next_tbl[tbl_idx(n)] = n;
            prev_tbl[tbl_idx(n)] = n;
            ring_head   = n;
            ring_vacant = 1'b0;
         end else begin
            tail = prev_tbl[tbl_idx(ring_head)];
            prev_tbl[tbl_idx(n)]         = tail;
            next_tbl[tbl_idx(n)]         = ring_head;
            next_tbl[tbl_idx(tail)]      = n;
            prev_tbl[tbl_idx(ring_head)] = n;
         end
         tail_loaded = n;
         return;
      end
      if (ring_vacant) return;
      case (op)
         clne_pkg::OP_INS_AFTER: begin
            r = next_tbl[tbl_idx(a)];
            prev_tbl[tbl_idx(n)] = a;
            next_tbl[tbl_idx(n)] = r;
            prev_tbl[tbl_idx(r)] = n;
            next_tbl[tbl_idx(a)] = n;
            if (a == tail_loaded) tail_loaded = n;
         end
         clne_pkg::OP_INS_BEFORE: begin
            r = prev_tbl[tbl_idx(a)];
            next_tbl[tbl_idx(n)] = a;
            prev_tbl[tbl_idx(n)] = r;
            next_tbl[tbl_idx(r)] = n;
            prev_tbl[tbl_idx(a)] = n;
            if (a == ring_head) ring_head = n;
         end
         clne_pkg::OP_CLOSE_NEXT: begin
            r   = next_tbl[tbl_idx(a)];
            far = next_tbl[tbl_idx(r)];
            if (r == a) begin
               ring_vacant = 1'b1;
            end else begin
               prev_tbl[tbl_idx(far)] = a;
               next_tbl[tbl_idx(a)]   = far;
               if (r == ring_head)   ring_head   = far;
               if (r == tail_loaded) tail_loaded = a;
            end
         end
         clne_pkg::OP_CLOSE_PREV: begin
            r   = prev_tbl[tbl_idx(a)];
            far = prev_tbl[tbl_idx(r)];
            if (r == a) begin
               ring_vacant = 1'b1;
            end else begin
               next_tbl[tbl_idx(far)] = a;
               prev_tbl[tbl_idx(a)]   = far;
               if (r == ring_head)   ring_head   = a;
               if (r == tail_loaded) tail_loaded = far;
            end
         end
         default: return;   // spare opcodes
      endcase
      gives = 1'b1;
      nb    = r;
   endfunction

   // Runs a request through the model and queues it with its expected neighbor.
   task automatic queue_cmd(input op_type op,
                            input id_type a,
                            input id_type n);
      ring_cmd_type c;
      bit           grows;
      c.op      = op;
      c.anchor  = a;
      c.station = n;
      step_ring(op, a, n, c.gives_nb, c.nb);
      grows = (op == clne_pkg::OP_LOAD) ||
              (c.gives_nb && (op == clne_pkg::OP_INS_AFTER ||
                              op == clne_pkg::OP_INS_BEFORE));
      // Links of n are written now, so n may later serve as an anchor
      if (grows && !id_seen[tbl_idx(n)]) begin
         id_seen[tbl_idx(n)] = 1'b1;
         known_ids.push_back(n);
      end
      if (ring_vacant)    ring_len = 0;
      else if (grows)     ring_len++;
      else if (c.gives_nb && ring_len > 1) ring_len--;
      pending_q.push_back(c);
   endtask

   // Idle cycles before the next transaction; occasional runs with no idling.
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm_left = $urandom_range(20, 40);
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ---------------------------------------------------------------------
   initial begin
      op_type op;
      id_type a, n;
      int     close_pct, hops;
      bit     draining;

      draining = 1'b0;

      // Empty ring: nothing answers, nothing is read
      queue_cmd(clne_pkg::OP_INS_AFTER,  16'hFFFF, 16'h0000);
      queue_cmd(clne_pkg::OP_INS_BEFORE, 16'h0000, 16'hFFFF);
      queue_cmd(clne_pkg::OP_CLOSE_NEXT, 16'h1234, 16'h5678);
      queue_cmd(clne_pkg::OP_CLOSE_PREV, 16'h0000, 16'h0000);
      queue_cmd(OP_SPARE_LO,             16'hFFFF, 16'hFFFF);
      queue_cmd(OP_SPARE_MID,            16'h0000, 16'hFFFF);
      queue_cmd(OP_SPARE_HI,             16'hFFFF, 16'h0000);
      // Single station closed from either side empties the ring
      queue_cmd(clne_pkg::OP_LOAD,       16'hFFFF, 16'h4321);
      queue_cmd(clne_pkg::OP_CLOSE_NEXT, 16'h4321, 16'h0000);
      queue_cmd(clne_pkg::OP_CLOSE_PREV, 16'h4321, 16'hFFFF);
      queue_cmd(clne_pkg::OP_LOAD,       16'h0000, 16'hBEEF);
      queue_cmd(clne_pkg::OP_CLOSE_PREV, 16'hBEEF, 16'h0000);
      // Ring built from extreme ids
      queue_cmd(clne_pkg::OP_LOAD,       16'h0000, 16'h0000);
      queue_cmd(clne_pkg::OP_LOAD,       16'hFFFF, 16'hFFFF);
      queue_cmd(clne_pkg::OP_LOAD,       16'h5A5A, 16'h8000);
      queue_cmd(clne_pkg::OP_LOAD,       16'hA5A5, 16'h0001);
      queue_cmd(clne_pkg::OP_INS_AFTER,  16'hFFFF, 16'h1234);
      // Insert before the start: new station becomes the start
      queue_cmd(clne_pkg::OP_INS_BEFORE, 16'h0000, 16'h7FFF);
      // Insert after the last appended station moves the append point
      queue_cmd(clne_pkg::OP_INS_AFTER,  16'h0001, 16'hAAAA);
      // Closing the start from behind moves it forward
      queue_cmd(clne_pkg::OP_CLOSE_NEXT, 16'hAAAA, 16'hFFFF);
      queue_cmd(clne_pkg::OP_CLOSE_PREV, 16'h0000, 16'h0000);
      // Closing the start from ahead makes the anchor the start
      queue_cmd(clne_pkg::OP_CLOSE_PREV, 16'hFFFF, 16'h5555);
      queue_cmd(OP_SPARE_HI,             16'h0001, 16'hFFFF);
      queue_cmd(clne_pkg::OP_LOAD,       16'hFFFF, 16'h5555);

      // Random part: mostly anchors found by walking the live ring and fresh
      // ids, with a little noise (stale anchors, reused ids, spare opcodes)
      for (int i = 0; i < RANDOM_CMDS; i++) begin
         if (ring_vacant) draining = 1'b0;
         else if (!draining && $urandom_range(0, 149) == 0) draining = 1'b1;
         a = id_type'($urandom);
         n = id_type'($urandom);
         if ($urandom_range(0, 99) < 4) begin
            op = op_type'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
         end else if (ring_vacant) begin
            op = ($urandom_range(0, 9) != 0)
                 ? clne_pkg::OP_LOAD
                 : op_type'($urandom_range(clne_pkg::OP_INS_AFTER, clne_pkg::OP_CLOSE_PREV));
         end else begin
            close_pct = draining ? 100 : (ring_len < 3) ? 10 : (ring_len > 48) ? 70 : 35;
            if ($urandom_range(0, 99) < close_pct) begin
               op = $urandom_range(0, 1) ? clne_pkg::OP_CLOSE_NEXT : clne_pkg::OP_CLOSE_PREV;
            end else begin
               case ($urandom_range(0, 2))
                  0:       op = clne_pkg::OP_LOAD;
                  1:       op = clne_pkg::OP_INS_AFTER;
                  default: op = clne_pkg::OP_INS_BEFORE;
               endcase
            end
         end
         if (!ring_vacant) begin
            if ($urandom_range(0, 99) < 6) begin
               a = known_ids[$urandom_range(0, known_ids.size() - 1)];
            end else begin
               a    = ring_head;
               hops = $urandom_range(0, (ring_len < 40) ? ring_len : 40);
               repeat (hops) a = next_tbl[tbl_idx(a)];
            end
         end
         if (op == clne_pkg::OP_LOAD || op == clne_pkg::OP_INS_AFTER ||
             op == clne_pkg::OP_INS_BEFORE) begin
            if (known_ids.size() > 0 && $urandom_range(0, 99) < 4)
               n = known_ids[$urandom_range(0, known_ids.size() - 1)];
            else if (!ring_vacant || op == clne_pkg::OP_LOAD)
               do n = id_type'($urandom); while (id_seen[tbl_idx(n)]);
         end
         queue_cmd(op, a, n);
      end
      total_cmds = pending_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (sent_count < total_cmds || neighbor_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("** circular_list_neighbor_engine_unit: PASSED **");
      end else begin
         $display("** circular_list_neighbor_engine_unit: FAILED **");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Driver: offers pending requests with random gaps between transactions
   // ---------------------------------------------------------------------
   ring_cmd_type cur_cmd;
   int           req_gap  = 0;
   int           req_calm = 0;

   always @(posedge clock) begin
      int gap_v;
      bit offering;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else begin
         offering = req_tvalid;
         gap_v    = req_gap;
         if (req_tvalid && req_tready) begin
            if (cur_cmd.gives_nb) neighbor_q.push_back(cur_cmd.nb);
            sent_count++;
            offering = 1'b0;
            gap_v    = draw_gap(req_calm);
         end
         if (!offering) begin
            if (gap_v > 0) begin
               gap_v--;
            end else if (pending_q.size() != 0) begin
               cur_cmd   = pending_q.pop_front();
               req_tdata <= {cur_cmd.station, cur_cmd.anchor};
               req_tuser <= cur_cmd.op;
               offering  = 1'b1;
            end
         end
         req_tvalid <= offering;
         req_gap    <= gap_v;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random back-pressure, two long hold-offs, in-order compare
   // ---------------------------------------------------------------------
   int rsp_stall = 0;
   int rsp_calm  = 0;
   int rsp_count = 0;

   always @(posedge clock) begin
      id_type want;
      int     stall_v;
      bit     ready_v;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else begin
         ready_v = rsp_tready;
         stall_v = rsp_stall;
         if (rsp_tvalid && rsp_tready) begin
            if (neighbor_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response transaction: neighbor %h", rsp_tdata);
            end else begin
               want = neighbor_q.pop_front();
               if (rsp_tdata !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("neighbor mismatch: expected %h, got %h", want, rsp_tdata);
               end
            end
            rsp_count++;
            // Long hold-off lets the engine fill up and stall its input
            stall_v = (rsp_count == 60 || rsp_count == 300) ? HOLD_CYCLES
                                                            : draw_gap(rsp_calm);
            if (stall_v != 0) ready_v = 1'b0;
         end else if (!rsp_tready) begin
            if (stall_v <= 1) ready_v = 1'b1;
            else stall_v--;
         end
         rsp_tready <= ready_v;
         rsp_stall  <= stall_v;
      end
   end

   // Watchdog: cycles in a row with no transaction on either channel
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** circular_list_neighbor_engine_unit: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
